// ----- rtl/core/vertical_curve_elevation_engine_core_macros.svh -----
// Assertion macros shared by the curve engine RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VERTICAL_CURVE_ELEVATION_ENGINE_CORE_MACROS_SVH
`define VERTICAL_CURVE_ELEVATION_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define VCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/vce_pkg.sv -----
// Shared constants, codes and handshake types for the vertical curve engine.
// No dependencies.
package vce_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int DVD_W  = 96;  // divider dividend, MSB aligned
  localparam int DVS_W  = 34;  // divider divisor
  localparam int QUO_W  = 49;  // kept quotient bits
  localparam int STEP_W = 7;   // iteration count
  localparam int MUL_W  = 33;  // shared multiplier operand width

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;

  localparam logic [QUO_W-1:0] GRADE_MAX = QUO_W'(64'h7FFF_FFFF);
  localparam logic [QUO_W-1:0] CORR_MAX  = QUO_W'(64'h1_0000_0000_0000);

  localparam logic [STEP_W-1:0] GRADE_STEPS = STEP_W'(48);
  localparam logic [STEP_W-1:0] CORR_STEPS  = STEP_W'(96);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_rsp_t;

endpackage

// ----- rtl/core/vertical_curve_elevation_engine_core.sv -----
// Vertical curve elevation engine: sorted grade point table and query sequencer.
// Depends on vce_pkg, vce_mul, vce_div and the assertion macro header.
//
//  channel | handshake        | word
//  --------+------------------+---------------------------------------------
//  in      | start / busy     | in_func, in_station, in_point_elevation
//  out     | out_valid strobe | out_curve_elevation, out_status
//  cfg     | cfg_we           | cfg_wdata (curve radius)
//
// Insert into N stored points: an insertion sort that moves each larger entry up one slot.
// Query over N points: scans the segments for the one that covers the station, fetches
// three entries, runs up to two grade divisions and one correction division in the
// shared divider, plus multiplier steps. Full/error words are answered straight from idle.
// Reset (synchronous, rst_n low) empties the table and zeroes the radius.
// The receiver cannot stall: each result word is shown for one cycle.
`include "vertical_curve_elevation_engine_core_macros.svh"
module vertical_curve_elevation_engine_core import vce_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_station,
  input  logic [31:0] in_point_elevation,
  output logic        out_valid,
  output logic [31:0] out_curve_elevation,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_WAIT, S_INS_CMP, S_INS_PUT,
    S_Q_W0, S_Q_C0, S_Q_WS, S_Q_CS,
    S_F_W, S_F_C,
    S_G1_S, S_G1_W, S_G2_S, S_G2_W,
    S_T_MUL, S_T_CAP, S_X_CAP,
    S_SQ_LL, S_SQ_HL, S_SQ_HH, S_SQ_END, S_C_W, S_FIN
  } state_t;

  localparam logic signed [51:0] SAT_HI = 52'sd2147483647;
  localparam logic signed [51:0] SAT_LO = -52'sd2147483648;

  state_t         state_r;
  logic [31:0]    radius_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  addr_r, k_r, j_r, i_r;
  logic [1:0]     fc_r;
  logic [31:0]    st_r, ne_r, prev_st_r;
  logic [31:0]    sp_r, ep_r, si_r, ei_r, sn_r, en_r;
  logic [31:0]    rd_st_r, rd_el_r;
  logic [31:0]    g1_r, g2_r;
  logic           om_neg_r;
  logic [46:0]    t_len_r, d_r;
  logic [31:0]    x_r;
  logic           g_neg_r, dx_neg_r;
  logic signed [49:0] tan_r;
  logic [95:0]    acc_r;
  logic [QUO_W-1:0] corr_r;
  logic           out_valid_r;
  logic [31:0]    out_elev_r;
  logic [1:0]     out_status_r;

  // table storage
  logic [31:0]    mem_st [MAX_POINTS];
  logic [31:0]    mem_el [MAX_POINTS];
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_st, wr_el;

  // shared units
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [QUO_W-1:0]   dq;

  // grade operands: entry a to entry b
  logic [31:0]        ga_s, ga_e, gb_s, gb_e;
  logic               g_ok;
  logic signed [32:0] g_de;
  logic [31:0]        g_mag, g_span;
  logic [30:0]        g_sat;
  logic [31:0]        g_val;

  logic signed [32:0] om;
  logic [32:0]        om_mag;
  logic [31:0]        g_sel;
  logic [30:0]        gm;
  logic [46:0]        term;
  logic [95:0]        sq_sum;
  logic [QUO_W-1:0]   c_sat;
  logic signed [51:0] sum;
  logic               ins_less;

  vce_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  vce_div u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .dvd(dvd), .dvs(dvs),
    .rsp(drsp), .q_r(dq)
  );

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_curve_elevation = out_elev_r;
  assign out_status          = out_status_r;

  assign ins_less = rd_st_r > st_r;

  // grade datapath: first grade uses (i-1, i), second (i, i+1)
  always_comb begin
    if (state_r == S_G1_S || state_r == S_G1_W) begin
      ga_s = sp_r; ga_e = ep_r; gb_s = si_r; gb_e = ei_r;
      g_ok = (i_r != '0) && (si_r > sp_r);
    end else begin
      ga_s = si_r; ga_e = ei_r; gb_s = sn_r; gb_e = en_r;
      g_ok = sn_r > si_r;
    end
    g_de   = $signed({gb_e[31], gb_e}) - $signed({ga_e[31], ga_e});
    g_mag  = g_de[32] ? 32'(-g_de) : g_de[31:0];
    g_span = gb_s - ga_s;
    g_sat  = (drsp.ovf || dq > GRADE_MAX) ? GRADE_MAX[30:0] : dq[30:0];
    g_val  = g_de[32] ? 32'(-{1'b0, g_sat}) : {1'b0, g_sat};
  end

  // tangent, multiplier and correction datapath
  always_comb begin
    om     = $signed({g2_r[31], g2_r}) - $signed({g1_r[31], g1_r});
    om_mag = om[32] ? 33'(-om) : 33'(om);
    g_sel  = (st_r <= si_r) ? g1_r : g2_r;
    gm     = g_sel[31] ? 31'(-g_sel) : g_sel[30:0];
    term   = mul_p[62:16];
    sq_sum = acc_r + {mul_p[47:0], 48'b0};
    c_sat  = (drsp.ovf || dq > CORR_MAX) ? CORR_MAX : dq;
    sum    = 52'(tan_r) + (om_neg_r ? -$signed({3'b0, corr_r}) : $signed({3'b0, corr_r}));

    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_T_MUL: begin
        mul_a = {1'b0, radius_r};
        mul_b = om_mag;
      end
      S_T_CAP: begin
        mul_a = {2'b0, gm};
        mul_b = {1'b0, (st_r < si_r) ? si_r - st_r : st_r - si_r};
      end
      S_SQ_LL: begin
        mul_a = {9'b0, d_r[23:0]};
        mul_b = {9'b0, d_r[23:0]};
      end
      S_SQ_HL: begin
        mul_a = {10'b0, d_r[46:24]};
        mul_b = {9'b0, d_r[23:0]};
      end
      S_SQ_HH: begin
        mul_a = {10'b0, d_r[46:24]};
        mul_b = {10'b0, d_r[46:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider launch
  always_comb begin
    dreq.start = 1'b0;
    dreq.steps = GRADE_STEPS;
    dvd        = {g_mag, 16'b0, 48'b0};
    dvs        = {2'b0, g_span};
    if ((state_r == S_G1_S || state_r == S_G2_S) && g_ok) begin
      dreq.start = 1'b1;
    end else if (state_r == S_SQ_END) begin
      dreq.start = 1'b1;
      dreq.steps = CORR_STEPS;
      dvd        = sq_sum;
      dvs        = {1'b0, radius_r, 1'b0};
    end
  end

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_r;
    wr_st   = st_r;
    wr_el   = ne_r;
    priority case (state_r)
      S_IDLE: begin
        wr_en   = start && (in_func == FUNC_INSERT) && (count_r == '0);
        wr_addr = '0;
        wr_st   = in_station;
        wr_el   = in_point_elevation;
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (ins_less) begin
          wr_st = rd_st_r;
          wr_el = rd_el_r;
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_st[wr_addr] <= wr_st;
      mem_el[wr_addr] <= wr_el;
    end
    rd_st_r <= mem_st[addr_r];
    rd_el_r <= mem_el[addr_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      radius_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) radius_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            st_r <= in_station;
            ne_r <= in_point_elevation;
            if (in_func == FUNC_INSERT) begin
              if (count_r >= CW'(MAX_POINTS)) begin
                out_valid_r  <= 1'b1;
                out_elev_r   <= '0;
                out_status_r <= ST_FULL;
              end else begin
                count_r <= count_r + CW'(1);
                k_r     <= count_r[AW-1:0];
                if (count_r == '0) begin
                  out_valid_r  <= 1'b1;
                  out_elev_r   <= '0;
                  out_status_r <= ST_OK;
                end else begin
                  addr_r  <= count_r[AW-1:0] - AW'(1);
                  state_r <= S_INS_WAIT;
                end
              end
            end else if (count_r < CW'(2)) begin
              out_valid_r  <= 1'b1;
              out_elev_r   <= '0;
              out_status_r <= ST_FEW;
            end else begin
              addr_r  <= '0;
              j_r     <= '0;
              state_r <= S_Q_W0;
            end
          end
        end
        S_INS_WAIT: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (ins_less) begin
            k_r <= k_r - AW'(1);
            if (k_r == AW'(1)) begin
              state_r <= S_INS_PUT;
            end else begin
              addr_r  <= k_r - AW'(2);
              state_r <= S_INS_WAIT;
            end
          end else begin
            out_valid_r  <= 1'b1;
            out_elev_r   <= '0;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end
        end
        S_INS_PUT: begin
          out_valid_r  <= 1'b1;
          out_elev_r   <= '0;
          out_status_r <= ST_OK;
          state_r      <= S_IDLE;
        end
        S_Q_W0: state_r <= S_Q_C0;
        S_Q_C0: begin
          prev_st_r <= rd_st_r;
          addr_r    <= AW'(1);
          state_r   <= S_Q_WS;
        end
        S_Q_WS: state_r <= S_Q_CS;
        S_Q_CS: begin
          if (prev_st_r <= st_r && st_r <= rd_st_r) begin
            i_r     <= j_r;
            fc_r    <= 2'd0;
            addr_r  <= (j_r == '0) ? '0 : j_r - AW'(1);
            state_r <= S_F_W;
          end else if (CW'(j_r) + CW'(2) < count_r) begin
            prev_st_r <= rd_st_r;
            j_r       <= j_r + AW'(1);
            addr_r    <= j_r + AW'(2);
            state_r   <= S_Q_WS;
          end else begin
            // no segment covers the station: extrapolate segment 0
            i_r     <= '0;
            fc_r    <= 2'd0;
            addr_r  <= '0;
            state_r <= S_F_W;
          end
        end
        S_F_W: state_r <= S_F_C;
        S_F_C: begin
          unique case (fc_r)
            2'd0: begin
              sp_r <= rd_st_r; ep_r <= rd_el_r;
              addr_r <= i_r; fc_r <= 2'd1; state_r <= S_F_W;
            end
            2'd1: begin
              si_r <= rd_st_r; ei_r <= rd_el_r;
              addr_r <= i_r + AW'(1); fc_r <= 2'd2; state_r <= S_F_W;
            end
            default: begin
              sn_r <= rd_st_r; en_r <= rd_el_r;
              state_r <= S_G1_S;
            end
          endcase
        end
        S_G1_S: begin
          if (g_ok) begin
            state_r <= S_G1_W;
          end else begin
            g1_r    <= '0;
            state_r <= S_G2_S;
          end
        end
        S_G1_W: begin
          if (drsp.done) begin
            g1_r    <= g_val;
            state_r <= S_G2_S;
          end
        end
        S_G2_S: begin
          if (g_ok) begin
            state_r <= S_G2_W;
          end else begin
            g2_r    <= '0;
            state_r <= S_T_MUL;
          end
        end
        S_G2_W: begin
          if (drsp.done) begin
            g2_r    <= g_val;
            state_r <= S_T_MUL;
          end
        end
        S_T_MUL: begin
          om_neg_r <= om[32];
          state_r  <= S_T_CAP;
        end
        S_T_CAP: begin
          t_len_r  <= mul_p[63:17];
          x_r      <= (st_r < si_r) ? si_r - st_r : st_r - si_r;
          dx_neg_r <= st_r < si_r;
          g_neg_r  <= g_sel[31];
          state_r  <= S_X_CAP;
        end
        S_X_CAP: begin
          if ((g_neg_r != dx_neg_r) && term != '0) begin
            tan_r <= $signed({{18{ei_r[31]}}, ei_r}) - $signed({3'b0, term});
          end else begin
            tan_r <= $signed({{18{ei_r[31]}}, ei_r}) + $signed({3'b0, term});
          end
          if (radius_r != '0 && {15'b0, x_r} <= t_len_r) begin
            d_r     <= t_len_r - {15'b0, x_r};
            state_r <= S_SQ_LL;
          end else begin
            corr_r  <= '0;
            state_r <= S_FIN;
          end
        end
        S_SQ_LL: state_r <= S_SQ_HL;
        S_SQ_HL: begin
          acc_r   <= {48'b0, mul_p[47:0]};
          state_r <= S_SQ_HH;
        end
        S_SQ_HH: begin
          acc_r   <= acc_r + {23'b0, mul_p[47:0], 25'b0};
          state_r <= S_SQ_END;
        end
        S_SQ_END: state_r <= S_C_W;
        S_C_W: begin
          if (drsp.done) begin
            corr_r  <= c_sat;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_OK;
          if (sum > SAT_HI)      out_elev_r <= 32'h7FFF_FFFF;
          else if (sum < SAT_LO) out_elev_r <= 32'h8000_0000;
          else                   out_elev_r <= sum[31:0];
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VCE_ASSERT_NXT(a_accept_acts, start && !busy, busy || out_valid, "accepted word dropped")
  `VCE_ASSERT_IMP(a_out_idle, out_valid, !busy, "result shown while busy")
  `VCE_ASSERT_IMP(a_count_max, 1'b1, count_r <= CW'(MAX_POINTS), "table count overflow")
  `VCE_ASSERT_IMP(a_err_zero, out_valid && out_status != ST_OK, out_curve_elevation == '0,
                  "nonzero elevation on error")

endmodule

// ----- rtl/core/vce_mul.sv -----
// Shared registered 33x33 unsigned multiplier.
// Depends on vce_pkg.
module vce_mul import vce_pkg::*; (
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- rtl/core/vce_div.sv -----
// Shared restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on vce_pkg.
module vce_div import vce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  input  logic [DVD_W-1:0]  dvd,
  input  logic [DVS_W-1:0]  dvs,
  output div_rsp_t          rsp,
  output logic [QUO_W-1:0]  q_r
);

  logic              busy_r;
  logic              done_r;
  logic              ovf_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;

  logic [DVS_W:0]    r_sh;
  logic              ge;
  logic [DVS_W-1:0]  rem_nxt;

  always_comb begin
    r_sh    = {rem_r, dvd_r[DVD_W-1]};
    ge      = r_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? DVS_W'(r_sh - {1'b0, dvs_r}) : r_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        dvd_r  <= dvd;
        dvs_r  <= dvs;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        q_r   <= {q_r[QUO_W-2:0], ge};
        ovf_r <= ovf_r | q_r[QUO_W-1];
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;

endmodule

// ----- bench/vce_checker.sv -----
// Checker for the vertical curve elevation engine: watches the command and result words,
// predicts each result from its own copy of the point table and radius, and counts mismatches.
// Depends on vce_pkg.
module vce_checker import vce_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_station,
  input  logic [31:0] in_point_elevation,
  input  logic        out_valid,
  input  logic [31:0] out_curve_elevation,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_words,
  output int          query_words,
  output int          full_words
);

  typedef struct packed {
    logic [31:0] elev;
    logic [1:0]  status;
  } elev_word_t;

  logic [31:0]        tbl_sta [MAX_POINTS];
  logic signed [31:0] tbl_elev[MAX_POINTS];
  int                 tbl_cnt;
  logic [31:0]        radius;
  elev_word_t         elev_expected_q[$];

  // Q16.16 grade from entry a to entry b
  function automatic longint grade_of(int a, int b);
    longint de;
    longint unsigned span, mag, q;
    de = longint'(tbl_elev[b]) - longint'(tbl_elev[a]);
    if (tbl_sta[b] <= tbl_sta[a]) return 0;
    span = longint'(tbl_sta[b]) - longint'(tbl_sta[a]);
    mag = (de < 0) ? -de : de;
    q = (mag << 16) / span;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return (de < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic elev_word_t predict_elevation(logic func, logic [31:0] sta,
                                                   logic [31:0] pe);
    elev_word_t w;
    int k, seg;
    longint g1, g2, omega, dx, g, tangent, corr, res;
    longint unsigned om_mag, t_len, x, gm, term;
    logic [127:0] sq;
    logic [127:0] cq;
    logic [31:0]  ts;
    logic signed [31:0] te;
    w = '0;
    if (func == FUNC_INSERT) begin
      if (tbl_cnt >= MAX_POINTS) begin
        w.status = ST_FULL;
      end else begin
        k = tbl_cnt;
        tbl_sta[k] = sta;
        tbl_elev[k] = pe;
        tbl_cnt++;
        while (k > 0 && tbl_sta[k] < tbl_sta[k-1]) begin
          ts = tbl_sta[k]; te = tbl_elev[k];
          tbl_sta[k] = tbl_sta[k-1]; tbl_elev[k] = tbl_elev[k-1];
          tbl_sta[k-1] = ts; tbl_elev[k-1] = te;
          k--;
        end
        w.status = ST_OK;
      end
      return w;
    end
    if (tbl_cnt < 2) begin
      w.status = ST_FEW;
      return w;
    end
    seg = 0;
    for (k = 0; k + 1 < tbl_cnt; k++)
      if (tbl_sta[k] <= sta && sta <= tbl_sta[k+1]) begin
        seg = k;
        break;
      end
    g1 = (seg > 0) ? grade_of(seg - 1, seg) : 0;
    g2 = grade_of(seg, seg + 1);
    omega = g2 - g1;
    om_mag = (omega < 0) ? -omega : omega;
    t_len = (longint'(radius) * om_mag) >> 17;
    dx = longint'(sta) - longint'(tbl_sta[seg]);
    g = (sta <= tbl_sta[seg]) ? g1 : g2;
    x = (dx < 0) ? -dx : dx;
    gm = (g < 0) ? -g : g;
    term = (gm * x) >> 16;
    tangent = ((g < 0) != (dx < 0) && term != 0) ? longint'(tbl_elev[seg]) - longint'(term)
                                                : longint'(tbl_elev[seg]) + longint'(term);
    corr = 0;
    if (radius != 0 && x <= t_len) begin
      sq = 128'(t_len - x) * 128'(t_len - x);
      cq = sq / (128'(radius) * 2);
      if (cq > 128'(64'h1_0000_0000_0000)) cq = 128'(64'h1_0000_0000_0000);
      corr = longint'(cq[63:0]);
      if (omega < 0) corr = -corr;
    end
    res = tangent + corr;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    w.elev = res[31:0];
    w.status = ST_OK;
    return w;
  endfunction

  always @(posedge clk) begin
    elev_word_t exp_w;
    int errs;
    if (!rst_n) begin
      tbl_cnt <= 0;
      radius <= '0;
      fail_count <= 0;
      pending_words <= 0;
      query_words <= 0;
      full_words <= 0;
      elev_expected_q.delete();
    end else begin
      errs = 0;
      // result words are checked before this edge's command updates the table
      if (out_valid) begin
        if (elev_expected_q.size() == 0) begin
          $error("unexpected result word: elev %0d status %0d",
                 $signed(out_curve_elevation), out_status);
          errs++;
        end else begin
          exp_w = elev_expected_q.pop_front();
          if (out_curve_elevation !== exp_w.elev) begin
            $error("curve_elevation: expected %0d actual %0d", $signed(exp_w.elev),
                   $signed(out_curve_elevation));
            errs++;
          end
          if (out_status !== exp_w.status) begin
            $error("status: expected %0d actual %0d", exp_w.status, out_status);
            errs++;
          end
        end
      end
      if (cfg_we) radius <= cfg_wdata;
      if (start && !busy) begin
        exp_w = predict_elevation(in_func, in_station, in_point_elevation);
        elev_expected_q.push_back(exp_w);
        if (in_func == FUNC_QUERY && exp_w.status == ST_OK) query_words <= query_words + 1;
        if (exp_w.status == ST_FULL) full_words <= full_words + 1;
      end
      fail_count <= fail_count + errs;
      pending_words <= elev_expected_q.size();
    end
  end

endmodule

// ----- bench/tb_vertical_curve_elevation_engine_core.sv -----
// Testbench top for the vertical curve elevation engine: drives command words and
// radius writes, and gives the verdict. Depends on vce_pkg, vce_checker and the core.
module tb_vertical_curve_elevation_engine_core;
  import vce_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = FUNC_INSERT;
  logic [31:0] in_station = '0;
  logic [31:0] in_point_elevation = '0;
  logic        out_valid;
  logic [31:0] out_curve_elevation;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count, pending_words, query_words, full_words;
  int          idle_pct;   // sender gap chance in percent
  int          word_count;

  always #5 clk = ~clk;

  vertical_curve_elevation_engine_core uut (.*);

  vce_checker chk (.*);

  // Hard stop. About 800 words plus gaps finish well before it.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Present one command word and hold it until the engine takes it.
  // A random gap with start low comes first.
  // start stays high afterwards; the next gap or the caller drops it.
  task automatic send_word(logic func, logic [31:0] sta, logic [31:0] pe);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_station <= sta;
    in_point_elevation <= pe;
    @(posedge clk);
    while (busy) @(posedge clk);
    word_count++;
  endtask

  // Radius write only with the engine idle and nothing outstanding.
  task automatic set_radius(logic [31:0] r);
    start <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending_words != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_elev();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20000)) - 10000);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // Add to the alignment at random: reset is not allowed again, so an empty table
  // only exists at the start; later phases keep adding until the table fills.
  task automatic random_phase(int n, logic [31:0] sbase, logic [31:0] sspan);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 30)
        send_word(FUNC_INSERT, sbase + $urandom_range(sspan), rnd_elev());
      else if ($urandom_range(99) < 90)
        send_word(FUNC_QUERY, sbase + $urandom_range(sspan) - 1000, $urandom());
      else
        send_word(FUNC_QUERY, $urandom(), $urandom());
    end
  endtask

  initial begin
    idle_pct = 0;
    word_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: queries on an empty and one-point table, then a short crest/sag alignment
    send_word(FUNC_QUERY, 32'd0, 32'd0);
    send_word(FUNC_INSERT, 32'd100_000, 32'd5_000);
    send_word(FUNC_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 32'd0, 32'd0);
    send_word(FUNC_QUERY, 32'd50_000, 32'd0);          // radius 0: no correction
    set_radius(32'd2_000_000);
    send_word(FUNC_INSERT, 32'd200_000, 32'd1_000);     // crest at 100000
    send_word(FUNC_INSERT, 32'd200_000, 32'd9_000);     // zero span pair
    send_word(FUNC_INSERT, 32'd400_000, 32'd30_000);    // sag
    send_word(FUNC_QUERY, 32'd99_000, 32'd0);
    send_word(FUNC_QUERY, 32'd101_000, 32'd0);
    send_word(FUNC_QUERY, 32'd200_000, 32'd0);
    send_word(FUNC_QUERY, 32'd250_000, 32'd0);
    send_word(FUNC_QUERY, 32'hFFFF_FFFF, 32'd0);        // uncovered: segment 0 extrapolated
    send_word(FUNC_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_word(FUNC_INSERT, 32'd1, 32'h8000_0000);       // steep grades, saturation
    send_word(FUNC_QUERY, 32'd0, 32'd0);
    send_word(FUNC_QUERY, 32'h8000_0000, 32'd0);
    set_radius(32'hFFFF_FFFF);
    send_word(FUNC_QUERY, 32'd1, 32'd0);
    send_word(FUNC_QUERY, 32'hFFFF_FFF0, 32'd0);
    send_word(FUNC_QUERY, 32'd150_000, 32'd0);

    // random: sender idles 25%, then 52%, then not at all
    idle_pct = 25;
    set_radius(32'd500_000);
    random_phase(150, 32'd0, 32'd2_000_000);
    set_radius(32'd1);
    random_phase(80, 32'd0, 32'd2_000_000);
    idle_pct = 52;
    set_radius($urandom());
    random_phase(150, 32'd0, 32'hFFFF_FFFF);
    idle_pct = 0;
    set_radius(32'd10_000_000);
    random_phase(150, 32'd0, 32'd3_000_000);
    // fill the table and hit the full status
    while (word_count < 700) send_word(FUNC_INSERT, $urandom(), rnd_elev());
    set_radius(32'hFFFF_FFFF);
    random_phase(60, 32'd0, 32'hFFFF_FFFF);
    set_radius(32'd0);
    random_phase(20, 32'd0, 32'hFFFF_FFFF);
    start <= 1'b0;

    repeat (4) @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d command words: %0d elevation queries, %0d table-full inserts.",
             word_count, query_words, full_words);
    $display("Radius swept from 0 to 2^32-1 with sender gaps of 25, 52 and 0 percent.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
